// ===== rtl/pdh_pkg.sv =====
package pdh_pkg;

  localparam int unsigned NUM_BINS_DEF = 256;
  localparam int unsigned POS_W        = 32;
  localparam int unsigned LEN_W        = 31;
  localparam int unsigned BINS_W       = 9;
  localparam int unsigned CNT_W        = 32;
  localparam int unsigned HIT_W        = 8;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 31;
  // wrapped difference fits 33 bits signed, magnitude up to 2^30
  localparam int unsigned DIFF_W       = 34;
  localparam int unsigned SQ_W         = 64;
  localparam int unsigned DIST_W       = 32;

  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;
  localparam logic [1:0] CMD_NOP   = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_BOX_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BINS_USED = 3'd4;

  // start/done handshake to the serial arithmetic units
  typedef struct packed {
    logic start;
  } pdh_go_t;

endpackage

// ===== rtl/pair_distance_histogram.sv =====
// Add pair: the wrap divides, squares, root and bin divide run bit-serially from
//   the input transfer to out_tvalid; a clear sweeps the histogram RAM one bin per cycle.
// Throughput: one item at a time; the next transfer is taken the cycle after the result
//   transfer.
// Reset: synchronous active-low rst_n, then a clearing pass over the histogram RAM
//   before the first input transfer.
module pair_distance_histogram
  import pdh_pkg::*;
#(
  parameter int unsigned NUM_BINS = NUM_BINS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // cmd[1:0], first_x, first_y, first_z, second_x, second_y, second_z, read_bin,
  // zero pad to 208 bits
  input  logic [207:0]          in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // bin_hit[7:0], in_range[8], bin_value[40:9], pairs_seen[72:41], zero pad
  output logic [79:0]           out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned AW = $clog2(NUM_BINS);
  localparam int unsigned CW = AW + 1;
  localparam int unsigned DVW = 64;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_DIFF, S_WDIV, S_WFIX, S_SQ, S_SQW, S_ROOT, S_ROOTW,
    S_BDIV, S_BDIVW, S_RD, S_RDW, S_UPD, S_OUT
  } state_t;

  state_t state_r;

  // configuration
  logic [LEN_W-1:0]  box_r [3];
  logic [LEN_W-1:0]  bin_width_r;
  logic [BINS_W-1:0] bins_used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r[0]    <= LEN_W'(655360);
      box_r[1]    <= LEN_W'(655360);
      box_r[2]    <= LEN_W'(655360);
      bin_width_r <= LEN_W'(6554);
      bins_used_r <= BINS_W'(256);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BOX_X:     box_r[0]    <= cfg_data;
        REG_BOX_Y:     box_r[1]    <= cfg_data;
        REG_BOX_Z:     box_r[2]    <= cfg_data;
        REG_BIN_WIDTH: bin_width_r <= cfg_data;
        REG_BINS_USED: bins_used_r <= cfg_data[BINS_W-1:0];
        default: ;
      endcase
    end
  end

  // effective bin limit, wide enough to hold NUM_BINS
  localparam int unsigned EW = (CW > BINS_W) ? CW : BINS_W;
  logic [EW-1:0] eff_bins;
  always_comb begin
    if (EW'(bins_used_r) < EW'(NUM_BINS)) eff_bins = EW'(bins_used_r);
    else eff_bins = EW'(NUM_BINS);
  end

  // input fields
  logic [1:0]       in_cmd;
  logic [POS_W-1:0] in_pos [6];
  logic [HIT_W-1:0] in_read_bin;
  assign in_cmd = in_tdata[1:0];
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      in_pos[i] = in_tdata[2 + 32*i +: 32];
    end
  end
  assign in_read_bin = in_tdata[201:194];

  // working registers
  logic [1:0]        cmd_r;
  logic [POS_W-1:0]  pos_r [6];
  logic [HIT_W-1:0]  rbin_r;
  logic [1:0]        axis_r;
  logic signed [DIFF_W-1:0] d_r;
  logic [DVW-1:0]    l_r;
  logic              neg_r;
  logic [DIFF_W-1:0] w_r [3];
  logic [SQ_W-1:0]   sq_r;
  logic [DIST_W-1:0] dist_r;
  logic [DIST_W-1:0] bin_r;
  logic              binok_r;
  logic [CNT_W-1:0]  pairs_r;
  logic [CW-1:0]     clr_r;
  logic [HIT_W-1:0]  o_hit_r;
  logic              o_inr_r;
  logic [CNT_W-1:0]  o_val_r;

  // shared divider
  pdh_go_t        div_go;
  logic [DVW-1:0] div_num, div_den, div_q, div_rem;
  logic           div_done;
  pdh_divu #(.NW(DVW), .DW(DVW)) u_div (
    .clk(clk), .rst_n(rst_n), .go(div_go), .num(div_num), .den(div_den),
    .done(div_done), .quot(div_q), .rem(div_rem)
  );

  pdh_go_t         sq_go;
  logic [31:0]     sq_a;
  logic [63:0]     sq_p;
  logic            sq_done;
  pdh_mulsq #(.AW(32)) u_sq (
    .clk(clk), .rst_n(rst_n), .go(sq_go), .a(sq_a), .done(sq_done), .prod(sq_p)
  );

  pdh_go_t           rt_go;
  logic              rt_done;
  logic [DIST_W-1:0] rt_root;
  pdh_isqrt u_rt (
    .clk(clk), .rst_n(rst_n), .go(rt_go), .n(sq_r), .done(rt_done), .root(rt_root)
  );

  // histogram memory
  logic             ram_we;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [CNT_W-1:0] ram_wdata, ram_rdata;
  pdh_ram #(.WIDTH(CNT_W), .DEPTH(NUM_BINS)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // wrap: k = floor((2d + L) / 2L); fed as |2d+L| with a sign fix afterwards
  logic signed [DIFF_W+1:0] wnum;
  logic [DIFF_W+1:0]        wmag;
  logic [LEN_W-1:0]         cur_len;
  always_comb begin
    cur_len = (box_r[axis_r] == '0) ? LEN_W'(1) : box_r[axis_r];
    wnum    = (DIFF_W+2)'(d_r) * 2 + $signed({3'b0, cur_len});
    wmag    = wnum[DIFF_W+1] ? (DIFF_W+2)'(-wnum) : wnum;
  end

  logic [DVW-1:0]        wrem;
  logic signed [DVW-1:0] wdbl;
  logic signed [DVW-1:0] wres;
  logic [CNT_W-1:0]      upd_val;
  logic [DIST_W-1:0]     wabs;
  always_comb begin
    // floor remainder: for a negative numerator it is 2L - rem unless rem is zero
    wrem = (neg_r && div_rem != '0) ? l_r - div_rem : div_rem;
    // 2d + L = 2L*k + r, so d - L*k = (r - L) / 2, always exact
    wdbl = $signed(wrem) - $signed(DVW'(l_r[DVW-1:1]));
    wres = wdbl >>> 1;
    wabs    = w_r[axis_r][DIFF_W-1] ? DIST_W'(-w_r[axis_r]) : DIST_W'(w_r[axis_r]);
    upd_val = (ram_rdata > 32'hFFFF_FFFD) ? 32'hFFFF_FFFF : ram_rdata + 32'd2;
  end

  // l_r holds 2L of the axis being wrapped; the read address holds steady so that
  // the registered read stays valid through the update
  always_comb begin
    div_go.start = 1'b0;
    div_num      = '0;
    div_den      = '0;
    sq_go.start  = 1'b0;
    rt_go.start  = 1'b0;
    sq_a         = wabs;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_raddr    = (cmd_r == CMD_READ) ? AW'(rbin_r) : bin_r[AW-1:0];
    case (state_r)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r[AW-1:0];
      end
      S_DIFF: begin
        div_go.start = 1'b1;
        div_num      = DVW'(wmag);
        div_den      = DVW'({cur_len, 1'b0});
      end
      S_SQ:    sq_go.start = 1'b1;
      S_ROOT:  rt_go.start = 1'b1;
      S_BDIV: begin
        div_go.start = 1'b1;
        div_num      = DVW'(dist_r);
        div_den      = DVW'(bin_width_r);
      end
      S_UPD: begin
        ram_we    = binok_r;
        ram_waddr = bin_r[AW-1:0];
        ram_wdata = upd_val;
      end
      default: ;
    endcase
  end

  logic in_fire, out_fire;
  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      pairs_r <= '0;
      axis_r  <= '0;
      cmd_r   <= CMD_NOP;
    end else begin
      case (state_r)
        S_CLR: begin
          // sweep one bin per cycle
          clr_r <= clr_r + 1'b1;
          if (clr_r == CW'(NUM_BINS - 1)) begin
            state_r <= (cmd_r == CMD_CLEAR) ? S_OUT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_fire) begin
            cmd_r  <= in_cmd;
            pos_r  <= in_pos;
            rbin_r <= in_read_bin;
            axis_r <= '0;
            case (in_cmd)
              CMD_ADD: begin
                state_r <= S_WDIV;
                d_r     <= DIFF_W'($signed(in_pos[0])) - DIFF_W'($signed(in_pos[3]));
              end
              CMD_READ: state_r <= S_RD;
              CMD_CLEAR: begin
                pairs_r <= '0;
                clr_r   <= '0;
                o_hit_r <= '0;
                o_inr_r <= 1'b0;
                o_val_r <= '0;
                state_r <= S_CLR;
              end
              default: begin
                o_hit_r <= '0;
                o_inr_r <= 1'b0;
                o_val_r <= '0;
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_WDIV: begin
          // latch the sign and 2L; the divider is started in S_DIFF
          neg_r   <= wnum[DIFF_W+1];
          l_r     <= DVW'({cur_len, 1'b0});
          state_r <= S_DIFF;
        end
        S_DIFF: state_r <= S_WFIX;
        S_WFIX: begin
          if (div_done) begin
            w_r[axis_r] <= DIFF_W'(wres);
            state_r     <= S_SQ;
          end
        end
        S_SQ: state_r <= S_SQW;
        S_SQW: begin
          if (sq_done) begin
            sq_r <= (axis_r == 2'd0) ? sq_p : sq_r + sq_p;
            if (axis_r == 2'd2) begin
              state_r <= S_ROOT;
            end else begin
              axis_r  <= axis_r + 1'b1;
              d_r     <= DIFF_W'($signed(pos_r[axis_r + 1]))
                         - DIFF_W'($signed(pos_r[axis_r + 4]));
              state_r <= S_WDIV;
            end
          end
        end
        S_ROOT: state_r <= S_ROOTW;
        S_ROOTW: begin
          if (rt_done) begin
            dist_r  <= rt_root;
            state_r <= S_BDIV;
          end
        end
        S_BDIV: begin
          state_r <= (bin_width_r == '0) ? S_UPD : S_BDIVW;
          binok_r <= 1'b0;
          bin_r   <= '0;
        end
        S_BDIVW: begin
          if (div_done) begin
            bin_r   <= div_q[DIST_W-1:0];
            binok_r <= (div_q[DVW-1:EW] == '0) && (div_q[EW-1:0] < eff_bins);
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_RDW;
        S_RDW: begin
          if (cmd_r == CMD_READ) begin
            o_hit_r <= rbin_r;
            o_inr_r <= (EW'(rbin_r) < eff_bins);
            o_val_r <= (32'(rbin_r) < 32'(NUM_BINS)) ? ram_rdata : '0;
            state_r <= S_OUT;
          end else begin
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          o_hit_r <= bin_r[HIT_W-1:0];
          o_inr_r <= binok_r;
          o_val_r <= binok_r ? upd_val : '0;
          if (pairs_r != '1) pairs_r <= pairs_r + 1'b1;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_fire) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tdata = {7'd0, pairs_r, o_val_r, o_inr_r, o_hit_r};

endmodule

// ===== rtl/pdh_ram.sv =====
module pdh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pdh_divu.sv =====
// Restoring divider, one quotient bit per cycle. Also serves as a signed
// floor divider via pre/post adjustment in the caller.
module pdh_divu
  import pdh_pkg::*;
#(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  pdh_go_t       go,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quot,
  output logic [DW-1:0] rem
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   r_r, r_nxt;
  logic [DW-1:0] d_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW:0]   trial;

  always_comb begin
    trial    = {r_r[DW-1:0], q_r[NW-1]};
    q_nxt    = q_r;
    r_nxt    = r_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (go.start) begin
      q_nxt    = num;
      r_nxt    = '0;
      cnt_nxt  = CW'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, d_r}) begin
        r_nxt = trial - {1'b0, d_r};
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        r_nxt = trial;
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    if (go.start) begin
      d_r <= den;
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r[DW-1:0];

endmodule

// ===== rtl/pdh_mulsq.sv =====
// Shift-add squarer, one multiplier bit per cycle.
module pdh_mulsq
  import pdh_pkg::*;
#(
  parameter int unsigned AW = 32
) (
  input  logic            clk,
  input  logic            rst_n,
  input  pdh_go_t         go,
  input  logic [AW-1:0]   a,
  output logic            done,
  output logic [2*AW-1:0] prod
);

  localparam int unsigned CW = $clog2(AW + 1);

  logic [2*AW-1:0] acc_r, acc_nxt;
  logic [2*AW-1:0] mcand_r, mcand_nxt;
  logic [AW-1:0]   mplier_r, mplier_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;

  always_comb begin
    acc_nxt    = acc_r;
    mcand_nxt  = mcand_r;
    mplier_nxt = mplier_r;
    cnt_nxt    = cnt_r;
    busy_nxt   = busy_r;
    done_nxt   = 1'b0;
    if (go.start) begin
      acc_nxt    = '0;
      mcand_nxt  = {{AW{1'b0}}, a};
      mplier_nxt = a;
      cnt_nxt    = CW'(AW);
      busy_nxt   = 1'b1;
    end else if (busy_r) begin
      if (mplier_r[0]) begin
        acc_nxt = acc_r + mcand_r;
      end
      mcand_nxt  = {mcand_r[2*AW-2:0], 1'b0};
      mplier_nxt = {1'b0, mplier_r[AW-1:1]};
      cnt_nxt    = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r    <= acc_nxt;
    mcand_r  <= mcand_nxt;
    mplier_r <= mplier_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

// ===== rtl/pdh_isqrt.sv =====
// Digit-by-digit integer square root, one result bit per cycle.
module pdh_isqrt
  import pdh_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  pdh_go_t           go,
  input  logic [SQ_W-1:0]   n,
  output logic              done,
  output logic [DIST_W-1:0] root
);

  localparam int unsigned CW = $clog2(DIST_W + 1);

  logic [SQ_W-1:0]   rem_r, rem_nxt;
  logic [SQ_W-1:0]   src_r, src_nxt;
  logic [DIST_W-1:0] q_r, q_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [SQ_W-1:0]   cur;
  logic [SQ_W-1:0]   trial;

  always_comb begin
    cur      = {rem_r[SQ_W-3:0], src_r[SQ_W-1:SQ_W-2]};
    trial    = {{(SQ_W-DIST_W){1'b0}}, q_r} << 2 | SQ_W'(1);
    rem_nxt  = rem_r;
    src_nxt  = src_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (go.start) begin
      rem_nxt  = '0;
      src_nxt  = n;
      q_nxt    = '0;
      cnt_nxt  = CW'(DIST_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      src_nxt = {src_r[SQ_W-3:0], 2'b00};
      if (cur >= trial) begin
        rem_nxt = cur - trial;
        q_nxt   = {q_r[DIST_W-2:0], 1'b1};
      end else begin
        rem_nxt = cur;
        q_nxt   = {q_r[DIST_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    src_r <= src_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign root = q_r;

endmodule

// ===== rtl/pdh_checker.sv =====
module pdh_checker
  import pdh_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic [207:0] in_tdata,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [79:0]  out_tdata
);

  // one item in flight: no input transfer while a result is offered
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");

  // result held until taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed under stall");

  // a clear holds off its result while the sweep runs
  a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tdata[1:0] == CMD_CLEAR |=> !out_tvalid)
    else $error("clear answered too early");

  // a result transfer is followed by an idle output cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> !out_tvalid) else $error("result repeated");

endmodule

bind pair_distance_histogram pdh_checker u_pdh_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .in_tdata(in_tdata), .out_tvalid(out_tvalid), .out_tready(out_tready),
  .out_tdata(out_tdata)
);
